// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C master transaction engine: the input and
// result words, the bus phase encoding, request and status codes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Request codes carried by each input word
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_BYTE  = 2'd3;

    // Completion status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ADDR_NACK = 2'd1;
    localparam logic [1:0] STAT_DATA_NACK = 2'd2;

    // Address byte masks: force the R/W bit
    localparam logic [7:0] ADDR_WR_MASK = 8'hfe;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_TX_LO  = 4'd2,
        PH_TX_HI  = 4'd3,
        PH_TXA_LO = 4'd4,
        PH_TXA_HI = 4'd5,
        PH_WAIT   = 4'd6,
        PH_RX_LO  = 4'd7,
        PH_RX_HI  = 4'd8,
        PH_RXA_LO = 4'd9,
        PH_RXA_HI = 4'd10,
        PH_STOP1  = 4'd11,
        PH_STOP2  = 4'd12,
        PH_STOP3  = 4'd13
    } t_phase;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  dev_addr;
        logic [7:0]  wr_byte;
        logic [15:0] byte_count;
        logic        sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       need_byte;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       done_res;
        logic [1:0] status;
        logic       busy_res;
    } t_out_word;

endpackage

// ===== hw/rtl/i2c_master_transaction_engine_core.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine_core
// I2C master that advances the bus by one timing tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one bus timing tick and may carry a command: start a
// write or read transaction, or supply the next write byte. The engine
// takes one word every clock cycle; the phase update for a tick is a single
// pass of logic from the phase registers to the result register, so the
// result word for a tick appears on the output in the cycle after the tick is
// taken and the input stays ready while the output register is free or
// being emptied in the same cycle. Back-pressure on the result side stalls
// the input only when the held result is not taken. A transaction sends a
// start, the address byte (bit 0 cleared for write, set for read), then the
// data bytes, each followed by an ACK slot, and ends with a three-tick stop.
// Write bytes are requested by need_byte; while it is shown the lines hold
// and the word carrying the byte already drives the low half of bit 7. An
// address NACK ends with status 1, a data NACK with status 2. Reads ACK
// every byte but the last. COUNT_WIDTH sets how many low bits of
// byte_count are used.
module i2c_master_transaction_engine_core
    import i2cm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // Bus phase and transaction state
    t_phase                 r_phase,       n_phase;
    logic [2:0]             r_bit_index,   n_bit_index;
    logic [7:0]             r_shift,       n_shift;
    logic [COUNT_WIDTH-1:0] r_bytes_left,  n_bytes_left;
    logic                   r_is_read,     n_is_read;
    logic [1:0]             r_err,         n_err;
    logic                   r_scl,         n_scl;
    logic                   r_sda,         n_sda;
    logic                   r_addr_flight, n_addr_flight;

    // Result register
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word w_result;

    logic                   w_accept;
    logic [COUNT_WIDTH-1:0] w_count;
    logic [COUNT_WIDTH-1:0] w_left_dec;
    logic [COUNT_WIDTH-1:0] w_txa_left;
    logic [7:0]             w_rx_shift;

    // Free the input while the result register is empty or its held result leaves this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_count    = i_in_word.byte_count[COUNT_WIDTH-1:0];
    assign w_left_dec = r_bytes_left - COUNT_WIDTH'(1);
    // The address byte does not count against the data bytes
    assign w_txa_left = r_addr_flight ? r_bytes_left : w_left_dec;
    // Merge the sampled SDA into the receive shifter at the current bit
    assign w_rx_shift = r_shift | (8'(i_in_word.sda_in) << r_bit_index);

    // Next state
    always_comb begin
        n_phase       = r_phase;
        n_bit_index   = r_bit_index;
        n_shift       = r_shift;
        n_bytes_left  = r_bytes_left;
        n_is_read     = r_is_read;
        n_err         = r_err;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_addr_flight = r_addr_flight;
        case (r_phase)
            PH_WAIT: begin
                if (i_in_word.req_type == REQ_BYTE) begin
                    n_shift     = i_in_word.wr_byte;
                    n_bit_index = 3'd7;
                    n_scl       = 1'b0;
                    n_sda       = i_in_word.wr_byte[7];
                    n_phase     = PH_TX_HI;
                end
            end
            PH_START,
            PH_TX_LO: begin
                n_scl   = 1'b0;
                n_sda   = r_shift[r_bit_index];
                n_phase = PH_TX_HI;
            end
            PH_TX_HI: begin
                n_scl = 1'b1;
                if (r_bit_index == 3'd0) begin
                    n_phase = PH_TXA_LO;
                end else begin
                    n_bit_index = r_bit_index - 3'd1;
                    n_phase     = PH_TX_LO;
                end
            end
            PH_TXA_LO: begin
                n_scl   = 1'b0;
                n_sda   = 1'b1;
                n_phase = PH_TXA_HI;
            end
            PH_TXA_HI: begin
                n_scl         = 1'b1;
                n_sda         = 1'b1;
                n_addr_flight = 1'b0;
                if (i_in_word.sda_in) begin
                    n_err   = r_addr_flight ? STAT_ADDR_NACK : STAT_DATA_NACK;
                    n_phase = PH_STOP1;
                end else begin
                    n_bytes_left = w_txa_left;
                    if (w_txa_left == '0) begin
                        n_phase = PH_STOP1;
                    end else if (r_is_read) begin
                        n_phase     = PH_RX_LO;
                        n_bit_index = 3'd7;
                        n_shift     = 8'd0;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            end
            PH_RX_LO: begin
                n_scl   = 1'b0;
                n_sda   = 1'b1;
                n_phase = PH_RX_HI;
            end
            PH_RX_HI: begin
                n_scl   = 1'b1;
                n_shift = w_rx_shift;
                if (r_bit_index == 3'd0) begin
                    n_phase = PH_RXA_LO;
                end else begin
                    n_bit_index = r_bit_index - 3'd1;
                    n_phase     = PH_RX_LO;
                end
            end
            PH_RXA_LO: begin
                n_scl   = 1'b0;
                // ACK while more than one byte remains, NACK the last
                n_sda   = (r_bytes_left == '0) || (r_bytes_left == COUNT_WIDTH'(1));
                n_phase = PH_RXA_HI;
            end
            PH_RXA_HI: begin
                n_scl        = 1'b1;
                n_bytes_left = w_left_dec;
                if (w_left_dec == '0) begin
                    n_phase = PH_STOP1;
                end else if (r_is_read) begin
                    n_phase     = PH_RX_LO;
                    n_bit_index = 3'd7;
                    n_shift     = 8'd0;
                end else begin
                    n_phase = PH_WAIT;
                end
            end
            PH_STOP1: begin
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_phase = PH_STOP2;
            end
            PH_STOP2: begin
                n_scl   = 1'b1;
                n_sda   = 1'b0;
                n_phase = PH_STOP3;
            end
            PH_STOP3: begin
                n_scl   = 1'b1;
                n_sda   = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                // Idle: a start request pulls SDA low with SCL still high
                if (i_in_word.req_type == REQ_WRITE || i_in_word.req_type == REQ_READ) begin
                    n_is_read     = (i_in_word.req_type == REQ_READ);
                    n_shift       = (i_in_word.req_type == REQ_READ)
                                    ? (i_in_word.dev_addr | ADDR_RD_BIT)
                                    : (i_in_word.dev_addr & ADDR_WR_MASK);
                    n_bytes_left  = w_count;
                    n_err         = STAT_OK;
                    n_addr_flight = 1'b1;
                    n_bit_index   = 3'd7;
                    n_sda         = 1'b0;
                    n_phase       = PH_TX_LO;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Result word
    always_comb begin
        w_result           = '0;
        w_result.scl       = n_scl;
        w_result.sda_out   = n_sda;
        w_result.busy_res  = 1'b1;
        case (r_phase)
            PH_WAIT: begin
                w_result.need_byte = (i_in_word.req_type != REQ_BYTE);
            end
            PH_RX_HI: begin
                if (r_bit_index == 3'd0) begin
                    w_result.rd_valid = 1'b1;
                    w_result.rd_byte  = w_rx_shift;
                end
            end
            PH_STOP3: begin
                w_result.done_res = 1'b1;
                w_result.busy_res = 1'b0;
                w_result.status   = r_err;
            end
            PH_START, PH_TX_LO, PH_TX_HI, PH_TXA_LO, PH_TXA_HI,
            PH_RX_LO, PH_RXA_LO, PH_RXA_HI, PH_STOP1, PH_STOP2: begin
                w_result.busy_res = 1'b1;
            end
            default: begin
                w_result.busy_res = (i_in_word.req_type == REQ_WRITE)
                                 || (i_in_word.req_type == REQ_READ);
            end
        endcase
    end

    // Advance the state only on a taken tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_index   <= 3'd7;
            r_shift       <= 8'd0;
            r_bytes_left  <= '0;
            r_is_read     <= 1'b0;
            r_err         <= STAT_OK;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_addr_flight <= 1'b0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_bit_index   <= n_bit_index;
            r_shift       <= n_shift;
            r_bytes_left  <= n_bytes_left;
            r_is_read     <= n_is_read;
            r_err         <= n_err;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
            r_addr_flight <= n_addr_flight;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hw/rtl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master transaction engine, bound to the core.
// ----------------------------------------------------------------------------
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // Never refuse input while the result register is free
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // Done closes the transaction: not busy, bus released
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.done_res |->
            !o_out_word.busy_res && o_out_word.scl && o_out_word.sda_out)
        else $error("done tick without released bus");

    // Status is reported on the done tick only
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.done_res |-> o_out_word.status == STAT_OK)
        else $error("status outside done tick");

    // A received byte completes with SCL high inside a transaction
    a_rd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.rd_valid |->
            o_out_word.scl && o_out_word.busy_res && !o_out_word.need_byte)
        else $error("read byte outside its sample tick");

endmodule

bind i2c_master_transaction_engine_core i2cm_checker u_i2cm_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master transaction engine. Every input
// word is one bus tick; a behavioural model of the engine predicts the SCL,
// SDA and status word for each accepted tick, and a checker compares every
// result word against the oldest prediction. Directed transfers come first,
// then random read and write traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cm_pkg::*;

    localparam int COUNT_W = 16;
    localparam logic [15:0] CNT_MASK = 16'((32'd1 << COUNT_W) - 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 16;

    // Read data patterns driven back on SDA while the engine samples
    localparam int FILL_RAND = 0;
    localparam int FILL_ZERO = 1;
    localparam int FILL_ONE  = 2;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    i2c_master_transaction_engine_core #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // ------------------------------------------------------------------------
    // Behavioural copy of the engine state, advanced once per accepted word
    // ------------------------------------------------------------------------
    t_phase      bus_ph     = PH_IDLE;
    logic [2:0]  bit_pos    = 3'd7;
    logic [7:0]  shreg      = 8'h00;
    logic [15:0] left_cnt   = 16'h0000;
    logic        rd_mode    = 1'b0;
    logic [1:0]  fail_code  = STAT_OK;
    logic        scl_q      = 1'b1;
    logic        sda_q      = 1'b1;
    logic        addr_phase = 1'b0;

    t_out_word   pending_ticks[$];   // predicted result words, oldest first
    logic [7:0]  wr_bytes_q[$];      // fixed write data for directed transfers

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int ticks_sent     = 0;
    int err_cnt        = 0;
    int cycle_cnt      = 0;
    int n_writes       = 0;
    int n_reads        = 0;
    int n_rd_bytes     = 0;
    int n_addr_nack    = 0;
    int n_data_nack    = 0;
    t_out_word want_w;

    // Move on after a byte and its ACK slot have gone through cleanly
    function automatic void byte_finished();
        if (left_cnt == 16'd0) begin
            bus_ph = PH_STOP1;
        end else if (rd_mode) begin
            bus_ph  = PH_RX_LO;
            bit_pos = 3'd7;
            shreg   = 8'h00;
        end else begin
            bus_ph = PH_WAIT;
        end
    endfunction

    // Work out the result word for one tick and advance the model
    function automatic t_out_word advance_bus(t_in_word w);
        t_out_word r;
        r = '0;
        r.busy_res = 1'b1;
        case (bus_ph)
            PH_WAIT: begin
                if (w.req_type == REQ_BYTE) begin
                    shreg   = w.wr_byte;
                    bit_pos = 3'd7;
                    scl_q   = 1'b0;
                    sda_q   = w.wr_byte[7];
                    bus_ph  = PH_TX_HI;
                end else begin
                    r.need_byte = 1'b1;
                end
            end
            PH_TX_LO: begin
                scl_q  = 1'b0;
                sda_q  = shreg[bit_pos];
                bus_ph = PH_TX_HI;
            end
            PH_TX_HI: begin
                scl_q = 1'b1;
                if (bit_pos == 3'd0) begin
                    bus_ph = PH_TXA_LO;
                end else begin
                    bit_pos = bit_pos - 3'd1;
                    bus_ph  = PH_TX_LO;
                end
            end
            PH_TXA_LO: begin
                scl_q  = 1'b0;
                sda_q  = 1'b1;
                bus_ph = PH_TXA_HI;
            end
            PH_TXA_HI: begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                if (w.sda_in) begin
                    fail_code = addr_phase ? STAT_ADDR_NACK : STAT_DATA_NACK;
                    bus_ph    = PH_STOP1;
                end else begin
                    if (!addr_phase)
                        left_cnt = (left_cnt - 16'd1) & CNT_MASK;
                    byte_finished();
                end
                addr_phase = 1'b0;
            end
            PH_RX_LO: begin
                scl_q  = 1'b0;
                sda_q  = 1'b1;
                bus_ph = PH_RX_HI;
            end
            PH_RX_HI: begin
                scl_q = 1'b1;
                if (w.sda_in)
                    shreg[bit_pos] = 1'b1;
                if (bit_pos == 3'd0) begin
                    r.rd_valid = 1'b1;
                    r.rd_byte  = shreg;
                    bus_ph     = PH_RXA_LO;
                end else begin
                    bit_pos = bit_pos - 3'd1;
                    bus_ph  = PH_RX_LO;
                end
            end
            PH_RXA_LO: begin
                // ACK every byte but the last
                scl_q  = 1'b0;
                sda_q  = (left_cnt > 16'd1) ? 1'b0 : 1'b1;
                bus_ph = PH_RXA_HI;
            end
            PH_RXA_HI: begin
                scl_q    = 1'b1;
                left_cnt = (left_cnt - 16'd1) & CNT_MASK;
                byte_finished();
            end
            PH_STOP1: begin
                scl_q  = 1'b0;
                sda_q  = 1'b0;
                bus_ph = PH_STOP2;
            end
            PH_STOP2: begin
                scl_q  = 1'b1;
                sda_q  = 1'b0;
                bus_ph = PH_STOP3;
            end
            PH_STOP3, PH_START: begin
                scl_q      = 1'b1;
                sda_q      = 1'b1;
                r.done_res = 1'b1;
                r.busy_res = 1'b0;
                r.status   = fail_code;
                bus_ph     = PH_IDLE;
            end
            default: begin
                // Idle, and any unused phase code behaves as idle
                bus_ph = PH_IDLE;
                if (w.req_type == REQ_WRITE || w.req_type == REQ_READ) begin
                    rd_mode    = (w.req_type == REQ_READ);
                    shreg      = rd_mode ? (w.dev_addr | ADDR_RD_BIT)
                                         : (w.dev_addr & ADDR_WR_MASK);
                    left_cnt   = w.byte_count & CNT_MASK;
                    fail_code  = STAT_OK;
                    addr_phase = 1'b1;
                    bit_pos    = 3'd7;
                    sda_q      = 1'b0;
                    bus_ph     = PH_TX_LO;
                end else begin
                    r.busy_res = 1'b0;
                end
            end
        endcase
        r.scl     = scl_q;
        r.sda_out = sda_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Give up if the run hangs well beyond any correct run
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // Hold off long enough for the engine to back up its input
                out_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge i_clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Sample at the falling edge: the handshake seen here is the one taken at
    // the next rising edge, and the prediction was queued at acceptance.
    always @(negedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_ticks.size() == 0) begin
                $display("%0t: result word with no prediction waiting, actual %0h",
                         $time, out_word);
                err_cnt++;
            end else begin
                want_w = pending_ticks.pop_front();
                check_field("scl",       8'(want_w.scl),       8'(out_word.scl));
                check_field("sda_out",   8'(want_w.sda_out),   8'(out_word.sda_out));
                check_field("need_byte", 8'(want_w.need_byte), 8'(out_word.need_byte));
                check_field("rd_byte",   want_w.rd_byte,       out_word.rd_byte);
                check_field("rd_valid",  8'(want_w.rd_valid),  8'(out_word.rd_valid));
                check_field("done_res",  8'(want_w.done_res),  8'(out_word.done_res));
                check_field("status",    8'(want_w.status),    8'(out_word.status));
                check_field("busy_res",  8'(want_w.busy_res),  8'(out_word.busy_res));
                if (want_w.rd_valid)
                    n_rd_bytes++;
                if (want_w.done_res && want_w.status == STAT_ADDR_NACK)
                    n_addr_nack++;
                if (want_w.done_res && want_w.status == STAT_DATA_NACK)
                    n_data_nack++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Plain tick with every other field scrambled
    function automatic t_in_word noise_word();
        t_in_word w;
        w.req_type   = REQ_TICK;
        w.dev_addr   = 8'($urandom_range(255));
        w.wr_byte    = 8'($urandom_range(255));
        w.byte_count = 16'($urandom_range(65535));
        w.sda_in     = 1'($urandom_range(1));
        return w;
    endfunction

    // Offer one word, hold it until taken, then predict its result
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        pending_ticks.push_back(advance_bus(w));
        ticks_sent++;
    endtask

    // Pause the sender until every predicted word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_ticks.size() != 0);
    endtask

    task automatic idle_ticks(input int n);
        t_in_word w;
        repeat (n) begin
            w = noise_word();
            // A stray byte supply while idle must be dropped
            if ($urandom_range(1) != 0)
                w.req_type = REQ_BYTE;
            send_word(w);
        end
    endtask

    // Drive one transaction to its stop. nack_at picks the ACK slot answered
    // with a NACK: 0 the address, k the k-th data byte, -1 none.
    task automatic run_transfer(input logic rd, input logic [7:0] addr,
                                input logic [15:0] cnt, input int nack_at,
                                input int wait_max, input int fill, input int noise_pct);
        t_in_word w;
        int acked;
        int waited;
        int wait_goal;
        acked     = 0;
        waited    = 0;
        wait_goal = $urandom_range(wait_max);
        w = noise_word();
        w.req_type   = rd ? REQ_READ : REQ_WRITE;
        w.dev_addr   = addr;
        w.byte_count = cnt;
        send_word(w);
        if (rd)
            n_reads++;
        else
            n_writes++;
        while (bus_ph != PH_IDLE) begin
            w = noise_word();
            // Start requests while busy must be ignored
            if ($urandom_range(99) < noise_pct)
                w.req_type = ($urandom_range(1) != 0) ? REQ_WRITE : REQ_READ;
            case (bus_ph)
                PH_WAIT: begin
                    if (waited >= wait_goal) begin
                        w.req_type = REQ_BYTE;
                        if (wr_bytes_q.size() != 0)
                            w.wr_byte = wr_bytes_q.pop_front();
                        waited    = 0;
                        wait_goal = $urandom_range(wait_max);
                    end else begin
                        waited++;
                    end
                end
                PH_TXA_HI: begin
                    w.sda_in = ((addr_phase ? 0 : acked + 1) == nack_at);
                    if (!addr_phase)
                        acked++;
                end
                PH_RX_HI: begin
                    if (fill != FILL_RAND)
                        w.sda_in = (fill == FILL_ONE);
                end
                default: begin
                    // Byte supplies nobody asked for
                    if (w.req_type != REQ_TICK && $urandom_range(2) == 0)
                        w.req_type = REQ_BYTE;
                end
            endcase
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_idle_ticks();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_ticks(4);
    endtask

    task automatic test_write_extremes();
        wr_bytes_q.push_back(8'h00);
        wr_bytes_q.push_back(8'hff);
        run_transfer(1'b0, 8'hff, 16'd2, -1, 4, FILL_RAND, 0);
    endtask

    task automatic test_zero_count();
        run_transfer(1'b0, 8'h00, 16'd0, -1, 0, FILL_RAND, 0);
        run_transfer(1'b1, 8'hff, 16'd0, -1, 0, FILL_RAND, 0);
    endtask

    task automatic test_reads();
        run_transfer(1'b1, 8'h00, 16'd1, -1, 0, FILL_ZERO, 0);
        run_transfer(1'b1, 8'hfe, 16'd2, -1, 0, FILL_ONE, 0);
    endtask

    task automatic test_nacks();
        run_transfer(1'b0, 8'h42, 16'd2, 0, 0, FILL_RAND, 0);
        run_transfer(1'b1, 8'h43, 16'd2, 0, 0, FILL_RAND, 0);
        // Full count, cut short by a NACK on the first data byte
        run_transfer(1'b0, 8'h9a, 16'hffff, 1, 2, FILL_RAND, 0);
    endtask

    task automatic test_busy_requests();
        run_transfer(1'b0, 8'h3c, 16'd1, -1, 3, FILL_RAND, 40);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        run_transfer(1'b1, 8'h5a, 16'd1, -1, 2, FILL_RAND, 0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_ticks, input int snd_pct, input int rcv_pct);
        int first;
        logic rd;
        logic [15:0] cnt;
        int nack_at;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks) begin
            rd      = 1'($urandom_range(1));
            nack_at = -1;
            if ($urandom_range(99) < 25) begin
                // Wide count: keep it short with an early NACK
                rd      = 1'b0;
                cnt     = 16'($urandom_range(65535));
                nack_at = $urandom_range(3);
            end else begin
                cnt = 16'($urandom_range(3));
                case ($urandom_range(9))
                    0: nack_at = 0;
                    1: nack_at = 1 + $urandom_range(2);
                    default: nack_at = -1;
                endcase
            end
            run_transfer(rd, 8'($urandom_range(255)), cnt, nack_at, 3, FILL_RAND, 8);
            idle_ticks($urandom_range(2));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_write_extremes();
        test_zero_count();
        test_reads();
        test_nacks();
        test_busy_requests();
        test_backpressure();
        test_random_traffic(30, 0, 0);
        test_random_traffic(30, 58, 0);
        test_random_traffic(30, 0, 58);
        test_random_traffic(30, 35, 35);

        // Let any stray result words surface before judging
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d bus ticks: %0d write and %0d read transfers, %0d bytes read,",
                 ticks_sent, n_writes, n_reads, n_rd_bytes);
        $display("%0d address NACK and %0d data NACK aborts; %0d mismatches.",
                 n_addr_nack, n_data_nack, err_cnt);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
